// ===== hdl/tfn_pkg.sv =====
// shared types and constants for the triangle face normal pipeline
`default_nettype none
package tfn_pkg;

    localparam int COORD_W   = 32;
    localparam int NORMAL_W  = 16;
    localparam int MANT_BITS = 30;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_tri;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic                       degenerate;
    } t_normal;

endpackage
`default_nettype wire

// ===== hdl/triangle_face_normal_top.sv =====
// pipelined unit face normal of a triangle in fixed point
//
// usage: present a triangle on i_tri with i_start high; a transfer takes
// place at every rising edge where i_start is high and o_busy is low.
// o_busy is high only during reset and the cycle after it, so one triangle
// can enter on every clock cycle.
// every triangle yields one result on o_normal, marked by o_valid for one
// cycle; the receiver takes it in that cycle and cannot stall the block.
// the result passes through the edge, split product, signed product, cross product,
// block shift, scaled magnitude, square and sum of squares registers, the square
// root pipeline with one root bit per stage, a setup register and one quotient bit
// per stage in the three divider lanes, and an output register.
// throughput is one triangle per clock.
// degenerate triangles (zero cross product) give zero components and the
// degenerate flag.
// reset is synchronous and active low; it drops all items in flight.
`default_nettype none
module triangle_face_normal_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire tfn_pkg::t_tri   i_tri,
    output logic                 o_valid,
    output tfn_pkg::t_normal     o_normal
);

    localparam int COORD_WIDTH  = tfn_pkg::COORD_W;
    localparam int NORMAL_WIDTH = tfn_pkg::NORMAL_W;
    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;
    localparam int HW   = (EW + 1) / 2;
    localparam int PPW  = 2 * HW;
    localparam int FPW  = 4 * HW + 2;
    localparam int PW   = 2 * EW;
    localparam int SPW  = PW + 1;
    localparam int CRW  = SPW + 1;
    localparam int MW   = SPW;
    localparam int TW   = $clog2(MW + 1);
    localparam int MB   = tfn_pkg::MANT_BITS;
    localparam int SQW  = 2 * MB;
    localparam int SW   = 2 * MB + 2;
    localparam int RW   = MB + 1;
    localparam int RMW  = RW + 4;
    localparam int DW   = RW + 1;
    localparam int RRW  = DW + 1;
    localparam int FB   = NORMAL_WIDTH - 1;
    localparam int QW   = FB + 1;
    localparam int NBW  = MB + QW + 1;
    localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
    localparam int PB [6] = '{5, 4, 3, 5, 4, 3};

    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;

    logic accept;
    assign accept = i_start && !r_busy;

    // stage 1: edges
    logic signed [CW-1:0] crd [9];
    logic signed [EW-1:0] n_e [6];
    logic signed [EW-1:0] r1_e [6];
    logic                 r1_v;

    always_comb begin
        crd[0] = CW'(i_tri.a_x);
        crd[1] = CW'(i_tri.a_y);
        crd[2] = CW'(i_tri.a_z);
        crd[3] = CW'(i_tri.b_x);
        crd[4] = CW'(i_tri.b_y);
        crd[5] = CW'(i_tri.b_z);
        crd[6] = CW'(i_tri.c_x);
        crd[7] = CW'(i_tri.c_y);
        crd[8] = CW'(i_tri.c_z);
        for (int k = 0; k < 3; k++) begin
            n_e[k]     = EW'(crd[3+k]) - EW'(crd[k]);
            n_e[3 + k] = EW'(crd[6+k]) - EW'(crd[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= accept;
        end
        r1_e <= n_e;
    end

    // stage 2: partial products of edge magnitudes
    logic [PPW-1:0] r2_ll [6];
    logic [PPW-1:0] r2_lh [6];
    logic [PPW-1:0] r2_hl [6];
    logic [PPW-1:0] r2_hh [6];
    logic           r2_ng [6];
    logic           r2_v;

    for (genvar j = 0; j < 6; j++) begin : g_pp
        logic [PPW-1:0] ma;
        logic [PPW-1:0] mb;
        logic [HW-1:0]  alo, ahi, blo, bhi;
        always_comb begin
            ma  = r1_e[PA[j]][EW-1] ? PPW'(-r1_e[PA[j]]) : PPW'(r1_e[PA[j]]);
            mb  = r1_e[PB[j]][EW-1] ? PPW'(-r1_e[PB[j]]) : PPW'(r1_e[PB[j]]);
            alo = ma[HW-1:0];
            ahi = ma[PPW-1:HW];
            blo = mb[HW-1:0];
            bhi = mb[PPW-1:HW];
        end
        always_ff @(posedge i_clk) begin
            r2_ll[j] <= PPW'(alo) * PPW'(blo);
            r2_lh[j] <= PPW'(alo) * PPW'(bhi);
            r2_hl[j] <= PPW'(ahi) * PPW'(blo);
            r2_hh[j] <= PPW'(ahi) * PPW'(bhi);
            r2_ng[j] <= r1_e[PA[j]][EW-1] ^ r1_e[PB[j]][EW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    // stage 3: signed products
    logic signed [SPW-1:0] r3_p [6];
    logic                  r3_v;

    for (genvar j = 0; j < 6; j++) begin : g_prod
        logic [FPW-1:0] n_mag;
        always_comb begin
            n_mag = FPW'(r2_ll[j]) + (FPW'(r2_lh[j]) << HW) + (FPW'(r2_hl[j]) << HW)
                  + (FPW'(r2_hh[j]) << (2 * HW));
        end
        always_ff @(posedge i_clk) begin
            r3_p[j] <= r2_ng[j] ? -SPW'(n_mag[PW-1:0]) : SPW'(n_mag[PW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    // stage 4: cross product, sign and magnitude
    logic [MW-1:0] r4_mag [3];
    logic          r4_neg [3];
    logic          r4_v;

    for (genvar i = 0; i < 3; i++) begin : g_cross
        logic signed [CRW-1:0] n_c;
        assign n_c = CRW'(r3_p[2*i]) - CRW'(r3_p[2*i+1]);
        always_ff @(posedge i_clk) begin
            r4_neg[i] <= n_c[CRW-1];
            r4_mag[i] <= n_c[CRW-1] ? MW'(-n_c) : MW'(n_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    // stage 5: block shift amount
    logic [MW-1:0] orw;
    logic [TW-1:0] n_top;
    logic [TW-1:0] n_sh;
    logic [MW-1:0] r5_mag [3];
    logic          r5_neg [3];
    logic [TW-1:0] r5_sh;
    logic          r5_deg;
    logic          r5_v;

    always_comb begin
        orw   = r4_mag[0] | r4_mag[1] | r4_mag[2];
        n_top = '0;
        for (int b = 0; b < MW; b++) begin
            if (orw[b]) begin
                n_top = TW'(b + 1);
            end
        end
        n_sh = (n_top > TW'(MB)) ? n_top - TW'(MB) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_mag <= r4_mag;
        r5_neg <= r4_neg;
        r5_sh  <= n_sh;
        r5_deg <= (orw == '0);
    end

    // stage 6: scaled magnitudes
    logic [MB-1:0] r6_m [3];
    logic          r6_neg [3];
    logic          r6_deg;
    logic          r6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        for (int i = 0; i < 3; i++) begin
            r6_m[i] <= MB'(r5_mag[i] >> r5_sh);
        end
        r6_neg <= r5_neg;
        r6_deg <= r5_deg;
    end

    // stage 7: squares
    logic [SQW-1:0] r7_sq [3];
    logic [MB-1:0]  r7_m [3];
    logic           r7_neg [3];
    logic           r7_deg;
    logic           r7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        for (int i = 0; i < 3; i++) begin
            r7_sq[i] <= SQW'(r6_m[i]) * SQW'(r6_m[i]);
        end
        r7_m   <= r6_m;
        r7_neg <= r6_neg;
        r7_deg <= r6_deg;
    end

    // stage 8: sum of squares
    logic [SW-1:0] r8_sum;
    logic [MB-1:0] r8_m [3];
    logic          r8_neg [3];
    logic          r8_deg;
    logic          r8_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
        r8_sum <= SW'(r7_sq[0]) + SW'(r7_sq[1]) + SW'(r7_sq[2]);
        r8_m   <= r7_m;
        r8_neg <= r7_neg;
        r8_deg <= r7_deg;
    end

    // square root, one root bit per stage
    logic [SW-1:0]  r_sq_rad  [RW+1];
    logic [RMW-1:0] r_sq_rem  [RW+1];
    logic [RW-1:0]  r_sq_root [RW+1];
    logic [MB-1:0]  r_sq_m    [RW+1][3];
    logic           r_sq_neg  [RW+1][3];
    logic           r_sq_deg  [RW+1];
    logic           r_sq_v    [RW+1];

    always_comb begin
        r_sq_rad[0]  = r8_sum;
        r_sq_rem[0]  = '0;
        r_sq_root[0] = '0;
        r_sq_m[0]    = r8_m;
        r_sq_neg[0]  = r8_neg;
        r_sq_deg[0]  = r8_deg;
        r_sq_v[0]    = r8_v;
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [RMW-1:0] n_rem;
        logic [RMW-1:0] trial;
        always_comb begin
            n_rem = {r_sq_rem[k][RMW-3:0], r_sq_rad[k][SW-1:SW-2]};
            trial = {RMW'(r_sq_root[k]) << 2} | RMW'(1);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_sq_rad[k+1] <= r_sq_rad[k] << 2;
            if (n_rem >= trial) begin
                r_sq_rem[k+1]  <= n_rem - trial;
                r_sq_root[k+1] <= {r_sq_root[k][RW-2:0], 1'b1};
            end else begin
                r_sq_rem[k+1]  <= n_rem;
                r_sq_root[k+1] <= {r_sq_root[k][RW-2:0], 1'b0};
            end
            r_sq_m[k+1]   <= r_sq_m[k];
            r_sq_neg[k+1] <= r_sq_neg[k];
            r_sq_deg[k+1] <= r_sq_deg[k];
        end
    end

    // divider setup: numerator m * 2^(F+1) + L over 2L
    logic [RRW-1:0] r_dv_rem  [QW+1][3];
    logic [QW-1:0]  r_dv_num  [QW+1][3];
    logic [QW-1:0]  r_dv_quo  [QW+1][3];
    logic [DW-1:0]  r_dv_den  [QW+1];
    logic           r_dv_neg  [QW+1][3];
    logic           r_dv_deg  [QW+1];
    logic           r_dv_v    [QW+1];

    for (genvar i = 0; i < 3; i++) begin : g_dset
        logic [NBW-1:0] n_num;
        assign n_num = (NBW'(r_sq_m[RW][i]) << QW) + NBW'(r_sq_root[RW]);
        always_ff @(posedge i_clk) begin
            r_dv_rem[0][i] <= RRW'(n_num >> QW);
            r_dv_num[0][i] <= n_num[QW-1:0];
            r_dv_quo[0][i] <= '0;
            r_dv_neg[0][i] <= r_sq_neg[RW][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_sq_v[RW];
        end
        r_dv_den[0] <= {r_sq_root[RW], 1'b0};
        r_dv_deg[0] <= r_sq_deg[RW];
    end

    // restoring division, one quotient bit per stage in each lane
    for (genvar k = 0; k < QW; k++) begin : g_div
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [RRW-1:0] n_rem;
            assign n_rem = {r_dv_rem[k][i][RRW-2:0], r_dv_num[k][i][QW-1]};
            always_ff @(posedge i_clk) begin
                if (n_rem >= RRW'(r_dv_den[k])) begin
                    r_dv_rem[k+1][i] <= n_rem - RRW'(r_dv_den[k]);
                    r_dv_quo[k+1][i] <= {r_dv_quo[k][i][QW-2:0], 1'b1};
                end else begin
                    r_dv_rem[k+1][i] <= n_rem;
                    r_dv_quo[k+1][i] <= {r_dv_quo[k][i][QW-2:0], 1'b0};
                end
                r_dv_num[k+1][i] <= r_dv_num[k][i] << 1;
                r_dv_neg[k+1][i] <= r_dv_neg[k][i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_dv_den[k+1] <= r_dv_den[k];
            r_dv_deg[k+1] <= r_dv_deg[k];
        end
    end

    // output: saturate, apply sign, force zeros when degenerate
    logic [NORMAL_WIDTH-1:0] n_cmp [3];
    logic [NORMAL_WIDTH-1:0] r_cmp [3];
    logic                    r_deg;
    logic                    r_out_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [QW-1:0] q;
            q = r_dv_quo[QW][i];
            if (!r_dv_neg[QW][i] && q[QW-1]) begin
                q = {1'b0, {(QW-1){1'b1}}};
            end
            if (r_dv_deg[QW]) begin
                n_cmp[i] = '0;
            end else if (r_dv_neg[QW][i]) begin
                n_cmp[i] = -NORMAL_WIDTH'(q);
            end else begin
                n_cmp[i] = NORMAL_WIDTH'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_dv_v[QW];
        end
        r_cmp <= n_cmp;
        r_deg <= r_dv_deg[QW];
    end

    assign o_valid             = r_out_v;
    assign o_normal.normal_x   = tfn_pkg::NORMAL_W'(signed'(r_cmp[0]));
    assign o_normal.normal_y   = tfn_pkg::NORMAL_W'(signed'(r_cmp[1]));
    assign o_normal.normal_z   = tfn_pkg::NORMAL_W'(signed'(r_cmp[2]));
    assign o_normal.degenerate = r_deg;

    // no transfer is lost between the edge and product stages
    a_pipe_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v |=> r2_v)
        else $error("edge stage item not advanced");

    // degenerate results carry zero components
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_normal.degenerate) |->
        (o_normal.normal_x == '0 && o_normal.normal_y == '0 && o_normal.normal_z == '0))
        else $error("degenerate result with nonzero normal");

    // a proper triangle never gives an all-zero normal
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_normal.degenerate) |->
        (o_normal.normal_x != '0 || o_normal.normal_y != '0 || o_normal.normal_z != '0))
        else $error("zero normal without degenerate flag");

    // the divider never sees a zero length for a proper triangle
    a_len_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[0] && !r_dv_deg[0]) |-> (r_dv_den[0] != '0))
        else $error("zero length on proper triangle");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// regression bench for the triangle face normal pipeline with a scoreboard class
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int LATENCY   = 57;
    localparam int N_RANDOM  = 1200;
    localparam longint LIMIT = 200000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    tfn_pkg::t_tri    i_tri;
    logic             o_valid;
    tfn_pkg::t_normal o_normal;

    int sender_idle_pct;
    longint cycle_cnt;
    int n_degen;
    int n_sat;

    triangle_face_normal_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_tri   (i_tri),
        .o_valid (o_valid),
        .o_normal(o_normal)
    );

    function automatic tfn_pkg::t_normal face_normal(tfn_pkg::t_tri t);
        tfn_pkg::t_normal r;
        logic signed [127:0] ux, uy, uz, vx, vy, vz;
        logic signed [127:0] n [3];
        logic [127:0] mag [3];
        logic neg [3];
        logic [63:0] m [3];
        logic [63:0] sum, len, q, cap, rem, bitv, num;
        logic signed [15:0] comp [3];
        int top, sh, bl;
        r = '0;
        ux = 128'(t.b_x) - 128'(t.a_x);
        uy = 128'(t.b_y) - 128'(t.a_y);
        uz = 128'(t.b_z) - 128'(t.a_z);
        vx = 128'(t.c_x) - 128'(t.a_x);
        vy = 128'(t.c_y) - 128'(t.a_y);
        vz = 128'(t.c_z) - 128'(t.a_z);
        n[0] = uy * vz - uz * vy;
        n[1] = uz * vx - ux * vz;
        n[2] = ux * vy - uy * vx;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = n[i] < 0;
            mag[i] = neg[i] ? -n[i] : n[i];
            bl = 0;
            for (int b = 0; b < 128; b++)
                if (mag[i][b]) bl = b + 1;
            if (bl > top) top = bl;
        end
        if (top == 0 || (ux == 0 && uy == 0 && uz == 0) || (vx == 0 && vy == 0 && vz == 0)) begin
            r.degenerate = 1'b1;
            return r;
        end
        sh = top > tfn_pkg::MANT_BITS ? top - tfn_pkg::MANT_BITS : 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = 64'(mag[i] >> sh);
            sum += m[i] * m[i];
        end
        // bitwise integer square root
        rem = sum;
        len = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= len + bitv) begin
                rem -= len + bitv;
                len = (len >> 1) + bitv;
            end else begin
                len >>= 1;
            end
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++) begin
            num = (m[i] << tfn_pkg::NORMAL_W) + len;
            q = num / (2 * len);
            cap = neg[i] ? (64'd1 << (tfn_pkg::NORMAL_W - 1))
                         : (64'd1 << (tfn_pkg::NORMAL_W - 1)) - 1;
            if (q > cap) q = cap;
            comp[i] = neg[i] ? -16'(q) : 16'(q);
        end
        r.normal_x = comp[0];
        r.normal_y = comp[1];
        r.normal_z = comp[2];
        return r;
    endfunction

    class normal_scoreboard;
        tfn_pkg::t_normal pending_normals[$];
        int n_sent, n_checked, n_errors;

        function void note_triangle(tfn_pkg::t_tri t);
            pending_normals = {pending_normals, face_normal(t)};
            n_sent++;
        endfunction

        function void check_normal(tfn_pkg::t_normal got);
            tfn_pkg::t_normal want;
            n_checked++;
            if (pending_normals.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_normals.pop_front();
            if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
                got.normal_z !== want.normal_z || got.degenerate !== want.degenerate) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("mismatch: expected x=%0d y=%0d z=%0d d=%0b got x=%0d y=%0d z=%0d d=%0b",
                        want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                        got.normal_x, got.normal_y, got.normal_z, got.degenerate);
            end
        endfunction
    endclass

    normal_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_valid) begin
            sb.check_normal(o_normal);
            if (o_normal.degenerate) n_degen++;
            if (o_normal.normal_x == 16'sh7fff || o_normal.normal_x == -16'sh8000) n_sat++;
        end
        if (cycle_cnt > LIMIT) begin
            $display("timeout");
            $display("triangle_face_normal_top regression: fail");
            $finish;
        end
    end

    task automatic send_triangle(tfn_pkg::t_tri t);
        logic busy_now;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_tri   <= t;
        i_start <= 1'b1;
        forever begin
            @(negedge i_clk);
            busy_now = o_busy;
            @(posedge i_clk);
            if (!busy_now) break;
        end
        sb.note_triangle(t);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_normals.size() != 0);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(64)) - 32);
            default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                             : 32'h80000000 + $urandom_range(3);
        endcase
    endfunction

    function automatic tfn_pkg::t_tri rand_triangle();
        tfn_pkg::t_tri t;
        int mode, kind;
        mode = $urandom_range(3);
        t.a_x = rand_coord(mode); t.a_y = rand_coord(mode); t.a_z = rand_coord(mode);
        t.b_x = rand_coord(mode); t.b_y = rand_coord(mode); t.b_z = rand_coord(mode);
        t.c_x = rand_coord(mode); t.c_y = rand_coord(mode); t.c_z = rand_coord(mode);
        kind = $urandom_range(19);
        // repeated corners, collinear corners and faces in a constant z plane
        if (kind == 0) begin
            t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end else if (kind == 1) begin
            t.c_x = t.a_x; t.c_y = t.a_y; t.c_z = t.a_z;
        end else if (kind == 2) begin
            t.c_x = t.a_x + 2 * (t.b_x - t.a_x);
            t.c_y = t.a_y + 2 * (t.b_y - t.a_y);
            t.c_z = t.a_z + 2 * (t.b_z - t.a_z);
        end else if (kind == 3) begin
            t.a_z = t.b_z; t.c_z = t.b_z;
        end
        return t;
    endfunction

    function automatic tfn_pkg::t_tri mk(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        tfn_pkg::t_tri t;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.c_x = cx; t.c_y = cy; t.c_z = cz;
        return t;
    endfunction

    initial begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MAXC = 32'h7fffffff;
        localparam logic [31:0] MINC = 32'h80000000;
        cycle_cnt = 0;
        n_degen = 0;
        n_sat = 0;
        sender_idle_pct = 0;
        i_start = 1'b0;
        i_tri = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // axis aligned faces in both orientations and one oblique face
        send_triangle(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_triangle(mk(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
        send_triangle(mk(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_triangle(mk(0, 0, 0, 0, 0, ONE, 0, ONE, 0));
        send_triangle(mk(0, 0, 0, 0, 0, ONE, ONE, 0, 0));
        send_triangle(mk(0, 0, 0, ONE, 0, 0, 0, 0, ONE));
        send_triangle(mk(0, 0, 0, ONE, ONE, 0, 0, ONE, ONE));
        // coordinate extremes, widest edges, and small triangles near the origin
        send_triangle(mk(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC));
        send_triangle(mk(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC));
        send_triangle(mk(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC));
        send_triangle(mk(MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC, MINC, MINC));
        send_triangle(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(mk(32'hffffffff, 0, 0, 0, 32'hffffffff, 0, 0, 0, 32'hffffffff));
        // degenerate: all equal, repeated corners, collinear
        send_triangle(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        send_triangle(mk(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
        send_triangle(mk(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0));
        send_triangle(mk(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        send_triangle(mk(MINC, MINC, MINC, 0, 0, 0, MAXC, MAXC, MAXC));
        // rounding near a half step
        send_triangle(mk(0, 0, 0, 3, 0, 0, 0, 4, 5));
        send_triangle(mk(0, 0, 0, 1, 2, 0, 0, 1, 3));
        wait_drained();

        // random triangles in three phases with the sender idle 30, 63 and 0 percent, with an occasional drain
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 63 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                if ($urandom_range(199) == 0) wait_drained();
                send_triangle(rand_triangle());
            end
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered %0d triangles: %0d degenerate, %0d saturated x components",
            sb.n_sent, n_degen, n_sat);
        $display("sender idling at 30, 63 and 0 percent; %0d mismatches", sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_normals.size() == 0)
            $display("triangle_face_normal_top regression: pass");
        else
            $display("triangle_face_normal_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
